// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define AST_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`define AST_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sqvs_pkg.sv =====
package sqvs_pkg;

  localparam int SLOT_COUNT      = 4096;
  localparam int SINE_TABLE_BITS = 10;
  localparam int CORDIC_STEPS    = 16;
  localparam int DIV_STEPS       = 16;
  localparam int LANES           = 4;

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_U = 2;
  localparam int LANE_V = 3;

  localparam logic [15:0] ANGLE_MASK = 16'(32'hFFFF << (16 - SINE_TABLE_BITS));
  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
  localparam logic [28:0] SLOT_C = 29'(SLOT_COUNT);

  localparam logic [31:0] ATAN_STEPS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef enum logic [1:0] {
    CFG_SCREEN_W = 2'd0,
    CFG_SCREEN_H = 2'd1,
    CFG_ATLAS_W  = 2'd2,
    CFG_ATLAS_H  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_e;

  typedef struct packed {
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0]        rect_w;
    logic [14:0]        rect_h;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
    logic [12:0]        tex_x;
    logic [12:0]        tex_y;
    logic [13:0]        tex_w;
    logic [13:0]        tex_h;
    logic [15:0]        turn_angle;
    logic [11:0]        slot;
  } item_t;

  typedef struct packed {
    logic [1:0]  corner;
    logic [13:0] vidx;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] tu;
    logic signed [16:0] tv;
    logic [15:0]        angle;
  } vtx_t;

  typedef struct packed {
    vtx_t               vtx;
    logic signed [15:0] s;
    logic signed [15:0] c;
  } rot_t;

  typedef struct packed {
    logic signed [39:0] n;
    logic [15:0]        d;
  } lane_t;

  typedef struct packed {
    logic [15:0] q;
    logic        sat_lo;
    logic        sat_hi;
  } quo_t;

  function automatic logic [11:0] slot_wrap(logic [11:0] s);
    logic [28:0] r;
    r = {17'b0, s};
    for (int i = 11; i >= 0; i--) begin
      if (r >= (SLOT_C << i)) begin
        r = r - (SLOT_C << i);
      end
    end
    return r[11:0];
  endfunction

endpackage

// ===== rtl/sprite_quad_vertex_setup_top.sv =====
// Channel  | Direction | Handshake                 | Payload
// sprite   | in        | in_valid_i / in_stall_o   | rect_*, shift_*, tex_*, turn_angle, slot
// vertex   | out       | out_valid_o / out_stall_i | corner, vertex_index, pos_*, tex_*, last
// config   | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// A sprite is taken per four vertices; its four vertices leave one per cycle unless the output stalls.
// After the sprite register, each vertex passes through 1 sequencer stage,
// 18 CORDIC stages (fold, 16 iterations, rounding), 3 geometry stages,
// 17 divider stages (setup plus one quotient bit per stage) and 1 output stage.
// A sprite may be taken while earlier vertices are still in flight.
// An output stall freezes the whole pipeline; the sprite register still fills.
// Reset clears valid bits and loads the default screen and atlas sizes.
`include "assert_macros.svh"

module sprite_quad_vertex_setup_top import sqvs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] rect_x_i,
  input  logic signed [15:0] rect_y_i,
  input  logic [14:0]        rect_w_i,
  input  logic [14:0]        rect_h_i,
  input  logic signed [15:0] shift_x_i,
  input  logic signed [15:0] shift_y_i,
  input  logic [12:0]        tex_x_i,
  input  logic [12:0]        tex_y_i,
  input  logic [13:0]        tex_w_i,
  input  logic [13:0]        tex_h_i,
  input  logic [15:0]        turn_angle_i,
  input  logic [11:0]        slot_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         corner_o,
  output logic [13:0]        vertex_index_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic [14:0]        tex_u_o,
  output logic [14:0]        tex_v_o,
  output logic               last_o
);

  logic [14:0] scr_w_q, scr_h_q;
  logic [13:0] atl_w_q, atl_h_q;
  logic [14:0] scr_w, scr_h;
  logic [13:0] atl_w, atl_h;
  logic        en;
  item_t       item;
  logic        vtx_valid, rot_valid, geo_valid, div_valid;
  vtx_t        vtx;
  rot_t        rot;
  side_t       geo_side, div_side;
  lane_t       lanes [LANES];
  quo_t        quo   [LANES];
  logic [15:0] qs    [LANES];
  logic        out_valid_q;
  side_t       out_side_q;
  logic [15:0] pos_x_q, pos_y_q;
  logic [14:0] tex_u_q, tex_v_q;
  logic [1:0]  exp_corner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= 15'd640;
      scr_h_q <= 15'd480;
      atl_w_q <= 14'd1024;
      atl_h_q <= 14'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SCREEN_W: scr_w_q <= cfg_data_i;
        CFG_SCREEN_H: scr_h_q <= cfg_data_i;
        CFG_ATLAS_W:  atl_w_q <= cfg_data_i[13:0];
        CFG_ATLAS_H:  atl_h_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // zero size acts as one
  assign scr_w = (scr_w_q == 15'd0) ? 15'd1 : scr_w_q;
  assign scr_h = (scr_h_q == 15'd0) ? 15'd1 : scr_h_q;
  assign atl_w = (atl_w_q == 14'd0) ? 14'd1 : atl_w_q;
  assign atl_h = (atl_h_q == 14'd0) ? 14'd1 : atl_h_q;

  assign en = !(out_valid_q && out_stall_i);

  always_comb begin
    item.rect_x     = rect_x_i;
    item.rect_y     = rect_y_i;
    item.rect_w     = rect_w_i;
    item.rect_h     = rect_h_i;
    item.shift_x    = shift_x_i;
    item.shift_y    = shift_y_i;
    item.tex_x      = tex_x_i;
    item.tex_y      = tex_y_i;
    item.tex_w      = tex_w_i;
    item.tex_h      = tex_h_i;
    item.turn_angle = turn_angle_i;
    item.slot       = slot_i;
  end

  sqvs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .item_i      (item),
    .in_stall_o  (in_stall_o),
    .vtx_valid_o (vtx_valid),
    .vtx_o       (vtx)
  );

  sqvs_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vtx_valid),
    .vtx_i   (vtx),
    .valid_o (rot_valid),
    .rot_o   (rot)
  );

  sqvs_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .scr_w_i (scr_w),
    .scr_h_i (scr_h),
    .atl_w_i (atl_w),
    .atl_h_i (atl_h),
    .valid_i (rot_valid),
    .rot_i   (rot),
    .valid_o (geo_valid),
    .side_o  (geo_side),
    .lane_o  (lanes)
  );

  sqvs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geo_valid),
    .side_i  (geo_side),
    .lane_i  (lanes),
    .valid_o (div_valid),
    .side_o  (div_side),
    .quo_o   (quo)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_sat
    logic [15:0] top;
    assign top   = (l == LANE_X || l == LANE_Y) ? 16'hFFFF : 16'h7FFF;
    assign qs[l] = quo[l].sat_lo ? 16'd0 : (quo[l].sat_hi ? top : quo[l].q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      exp_corner_q <= CORNER_TL;
    end else begin
      if (en) begin
        out_valid_q <= div_valid;
      end
      if (out_valid_q && !out_stall_i) begin
        exp_corner_q <= exp_corner_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_side_q <= div_side;
      pos_x_q    <= {~qs[LANE_X][15], qs[LANE_X][14:0]};
      pos_y_q    <= {~qs[LANE_Y][15], qs[LANE_Y][14:0]};
      tex_u_q    <= qs[LANE_U][14:0];
      tex_v_q    <= qs[LANE_V][14:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign corner_o       = out_side_q.corner;
  assign vertex_index_o = out_side_q.vidx;
  assign pos_x_o        = signed'(pos_x_q);
  assign pos_y_o        = signed'(pos_y_q);
  assign tex_u_o        = tex_u_q;
  assign tex_v_o        = tex_v_q;
  assign last_o         = (out_side_q.corner == CORNER_BL);

  `AST_IMPLY(a_corner_order, out_valid_o, corner_o == exp_corner_q, "vertex out of order")
  `AST_IMPLY(a_index_corner, out_valid_o, vertex_index_o[1:0] == corner_o, "index mismatch")
  `AST_IMPLY(a_sat_excl, div_valid, !(quo[LANE_X].sat_lo && quo[LANE_X].sat_hi), "both saturations")

endmodule

// ===== rtl/sqvs_seq.sv =====
module sqvs_seq import sqvs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  in_valid_i,
  input  item_t item_i,
  output logic  in_stall_o,
  output logic  vtx_valid_o,
  output vtx_t  vtx_o
);

  item_t      item_q;
  logic       item_valid_q, item_valid_d;
  logic [1:0] cnt_q;
  logic       done, accept, use_w, use_h;
  logic [16:0] tx_sum, ty_sum;
  logic signed [16:0] u_lo, u_hi, v_lo, v_hi;
  vtx_t       vtx_d, vtx_q;
  logic       vtx_valid_q;

  assign done       = en_i && item_valid_q && (cnt_q == CORNER_BL);
  assign in_stall_o = item_valid_q && !done;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (done) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      cnt_q        <= 2'd0;
      vtx_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      if (en_i) begin
        vtx_valid_q <= item_valid_q;
        if (item_valid_q) begin
          cnt_q <= cnt_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (en_i) begin
      vtx_q <= vtx_d;
    end
  end

  always_comb begin
    use_w  = (cnt_q == CORNER_TR) || (cnt_q == CORNER_BR);
    use_h  = (cnt_q == CORNER_BR) || (cnt_q == CORNER_BL);
    tx_sum = 17'(item_q.tex_x) + 17'(item_q.tex_w);
    ty_sum = 17'(item_q.tex_y) + 17'(item_q.tex_h);
    u_lo   = signed'({3'b0, item_q.tex_x, 1'b1});
    v_lo   = signed'({3'b0, item_q.tex_y, 1'b1});
    u_hi   = signed'({tx_sum[15:0], 1'b0} - 17'd1);
    v_hi   = signed'({ty_sum[15:0], 1'b0} - 17'd1);

    vtx_d.side.corner = cnt_q;
    vtx_d.side.vidx   = {slot_wrap(item_q.slot), cnt_q};
    vtx_d.cx = 17'(item_q.rect_x) + signed'({3'b0, item_q.rect_w[14:1]});
    vtx_d.cy = 17'(item_q.rect_y) + signed'({3'b0, item_q.rect_h[14:1]});
    vtx_d.dx = 17'(item_q.shift_x) + (use_w ? signed'({2'b0, item_q.rect_w}) : 17'sd0)
               - signed'({3'b0, item_q.rect_w[14:1]});
    vtx_d.dy = 17'(item_q.shift_y) + (use_h ? signed'({2'b0, item_q.rect_h}) : 17'sd0)
               - signed'({3'b0, item_q.rect_h[14:1]});
    vtx_d.tu    = use_w ? u_hi : u_lo;
    vtx_d.tv    = use_h ? v_lo : v_hi;
    vtx_d.angle = item_q.turn_angle;
  end

  assign vtx_valid_o = vtx_valid_q;
  assign vtx_o       = vtx_q;

endmodule

// ===== rtl/sqvs_cordic.sv =====
module sqvs_cordic import sqvs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  vtx_t vtx_i,
  output logic valid_o,
  output rot_t rot_o
);

  logic               valid_q [CORDIC_STEPS+1];
  vtx_t               vtx_q   [CORDIC_STEPS+1];
  logic signed [32:0] x_q     [CORDIC_STEPS+1];
  logic signed [32:0] y_q     [CORDIC_STEPS+1];
  logic signed [32:0] z_q     [CORDIC_STEPS+1];
  logic               flip_q  [CORDIC_STEPS+1];

  logic [31:0]        a;
  logic               flip;
  logic signed [16:0] ys_t, xs_t;
  logic signed [15:0] s_d, c_d;
  logic               out_valid_q;
  rot_t               rot_q, rot_d;

  // fold into +-90 degrees
  always_comb begin
    a    = {vtx_i.angle & ANGLE_MASK, 16'h0000};
    flip = a[31] ^ a[30];
    if (flip) begin
      a[31] = ~a[31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vtx_q[0]  <= vtx_i;
      x_q[0]    <= CORDIC_X0;
      y_q[0]    <= 33'sd0;
      z_q[0]    <= 33'(signed'(a));
      flip_q[0] <= flip;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_iter
    logic signed [32:0] xs, ys, at;
    assign xs = x_q[g] >>> g;
    assign ys = y_q[g] >>> g;
    assign at = signed'({1'b0, ATAN_STEPS[g]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[g+1] <= valid_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vtx_q[g+1]  <= vtx_q[g];
        flip_q[g+1] <= flip_q[g];
        if (!z_q[g][32]) begin
          x_q[g+1] <= x_q[g] - ys;
          y_q[g+1] <= y_q[g] + xs;
          z_q[g+1] <= z_q[g] - at;
        end else begin
          x_q[g+1] <= x_q[g] + ys;
          y_q[g+1] <= y_q[g] - xs;
          z_q[g+1] <= z_q[g] + at;
        end
      end
    end
  end

  always_comb begin
    ys_t = 17'((y_q[CORDIC_STEPS] + 33'sd32768) >>> 16);
    xs_t = 17'((x_q[CORDIC_STEPS] + 33'sd32768) >>> 16);
    if (ys_t > 17'sd16384) begin
      s_d = 16'sd16384;
    end else if (ys_t < -17'sd16384) begin
      s_d = -16'sd16384;
    end else begin
      s_d = 16'(ys_t);
    end
    if (xs_t > 17'sd16384) begin
      c_d = 16'sd16384;
    end else if (xs_t < -17'sd16384) begin
      c_d = -16'sd16384;
    end else begin
      c_d = 16'(xs_t);
    end
    if (flip_q[CORDIC_STEPS]) begin
      s_d = -s_d;
      c_d = -c_d;
    end
    rot_d.vtx = vtx_q[CORDIC_STEPS];
    if (vtx_q[CORDIC_STEPS].angle == 16'd0) begin
      rot_d.s = 16'sd0;
      rot_d.c = 16'sd16384;
    end else begin
      rot_d.s = s_d;
      rot_d.c = c_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= valid_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = out_valid_q;
  assign rot_o   = rot_q;

endmodule

// ===== rtl/sqvs_geom.sv =====
module sqvs_geom import sqvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [14:0] scr_w_i,
  input  logic [14:0] scr_h_i,
  input  logic [13:0] atl_w_i,
  input  logic [13:0] atl_h_i,
  input  logic        valid_i,
  input  rot_t        rot_i,
  output logic        valid_o,
  output side_t       side_o,
  output lane_t       lane_o [LANES]
);

  logic               a_valid_q, b_valid_q, c_valid_q;
  side_t              a_side_q, b_side_q, c_side_q;
  logic signed [16:0] a_cx_q, a_cy_q, a_tu_q, a_tv_q, b_tu_q, b_tv_q;
  logic signed [32:0] a_xc_q, a_ys_q, a_xs_q, a_yc_q;
  logic signed [35:0] b_px_q, b_py_q;
  lane_t              c_lane_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_side_q <= rot_i.vtx.side;
      a_cx_q   <= rot_i.vtx.cx;
      a_cy_q   <= rot_i.vtx.cy;
      a_tu_q   <= rot_i.vtx.tu;
      a_tv_q   <= rot_i.vtx.tv;
      a_xc_q   <= 33'(rot_i.vtx.dx) * 33'(rot_i.c);
      a_ys_q   <= 33'(rot_i.vtx.dy) * 33'(rot_i.s);
      a_xs_q   <= 33'(rot_i.vtx.dx) * 33'(rot_i.s);
      a_yc_q   <= 33'(rot_i.vtx.dy) * 33'(rot_i.c);

      b_side_q <= a_side_q;
      b_tu_q   <= a_tu_q;
      b_tv_q   <= a_tv_q;
      b_px_q   <= (36'(a_cx_q) <<< 14) + 36'(a_xc_q) - 36'(a_ys_q);
      b_py_q   <= (36'(a_cy_q) <<< 14) + 36'(a_xs_q) + 36'(a_yc_q);

      // position lanes: 4p + 32769*sz biases the quotient into 0..65535
      c_side_q           <= b_side_q;
      c_lane_q[LANE_X].n <= signed'((40'(b_px_q) <<< 2) + {10'b0, scr_w_i, 15'b0}
                                    + 40'(scr_w_i));
      c_lane_q[LANE_X].d <= {scr_w_i, 1'b0};
      c_lane_q[LANE_Y].n <= signed'((40'(b_py_q) <<< 2) + {10'b0, scr_h_i, 15'b0}
                                    + 40'(scr_h_i));
      c_lane_q[LANE_Y].d <= {scr_h_i, 1'b0};
      c_lane_q[LANE_U].n <= signed'((40'(b_tu_q) <<< 15) + 40'(atl_w_i));
      c_lane_q[LANE_U].d <= {1'b0, atl_w_i, 1'b0};
      c_lane_q[LANE_V].n <= signed'((40'(b_tv_q) <<< 15) + 40'(atl_h_i));
      c_lane_q[LANE_V].d <= {1'b0, atl_h_i, 1'b0};
    end
  end

  assign valid_o = c_valid_q;
  assign side_o  = c_side_q;
  assign lane_o  = c_lane_q;

endmodule

// ===== rtl/sqvs_div.sv =====
module sqvs_div import sqvs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  side_t side_i,
  input  lane_t lane_i [LANES],
  output logic  valid_o,
  output side_t side_o,
  output quo_t  quo_o [LANES]
);

  logic        valid_q [DIV_STEPS+1];
  side_t       side_q  [DIV_STEPS+1];
  logic [31:0] rem_q   [DIV_STEPS+1][LANES];
  logic [15:0] d_q     [DIV_STEPS+1][LANES];
  logic [15:0] q_q     [DIV_STEPS+1][LANES];
  logic        lo_q    [DIV_STEPS+1][LANES];
  logic        hi_q    [DIV_STEPS+1][LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [39:0] lim;
    // position lanes carry a 16-bit quotient, texcoord lanes 15 bits
    assign lim = (l == LANE_X || l == LANE_Y) ? {8'b0, lane_i[l].d, 16'b0}
                                              : {9'b0, lane_i[l].d, 15'b0};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0][l] <= lane_i[l].n[31:0];
        d_q[0][l]   <= lane_i[l].d;
        q_q[0][l]   <= 16'd0;
        lo_q[0][l]  <= lane_i[l].n[39];
        hi_q[0][l]  <= !lane_i[l].n[39] && (unsigned'(lane_i[l].n) >= lim);
      end
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k+1] <= side_q[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [31:0] sh;
      logic        ge;
      assign sh = 32'(d_q[k][l]) << (DIV_STEPS - 1 - k);
      assign ge = rem_q[k][l] >= sh;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1][l] <= ge ? (rem_q[k][l] - sh) : rem_q[k][l];
          q_q[k+1][l]   <= {q_q[k][l][14:0], ge};
          d_q[k+1][l]   <= d_q[k][l];
          lo_q[k+1][l]  <= lo_q[k][l];
          hi_q[k+1][l]  <= hi_q[k][l];
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l].q      = q_q[DIV_STEPS][l];
    assign quo_o[l].sat_lo = lo_q[DIV_STEPS][l];
    assign quo_o[l].sat_hi = hi_q[DIV_STEPS][l];
  end

  assign valid_o = valid_q[DIV_STEPS];
  assign side_o  = side_q[DIV_STEPS];

endmodule

// ===== tb/sv/sprite_quad_vertex_checker.sv =====
`timescale 1ns / 100ps

module sprite_quad_vertex_checker import sqvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  cfg_idx_e    cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  item_t       sprite_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  corner_i,
  input  logic [13:0] vertex_index_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [14:0] tex_u_i,
  input  logic [14:0] tex_v_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [1:0]  corner;
    logic [13:0] vidx;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [14:0] tex_u;
    logic [14:0] tex_v;
    logic        last;
  } vertex_t;

  vertex_t vertex_q[$];
  longint  screen_w, screen_h, atlas_w, atlas_h;

  assign pending_o = vertex_q.size();

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint round_quot(longint n, longint d);
    return floor_quot(2 * n + d, 2 * d);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void sin_cos(logic [15:0] ang, output longint s, output longint c);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, xs, ys;
    a = {ang, 16'h0};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h8000_0000;
    z = longint'(int'(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_STEPS[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_STEPS[i]);
      end
    end
    s = clip((y + 32768) >>> 16, -16384, 16384);
    c = clip((x + 32768) >>> 16, -16384, 16384);
    if (flip) begin
      s = -s; c = -c;
    end
  endfunction

  function automatic logic [15:0] screen_coord(longint p14, longint sz);
    longint d;
    d = (sz == 0) ? 1 : sz;
    return 16'(clip(round_quot(2 * p14 - d * 16384, d), -32768, 32767));
  endfunction

  function automatic logic [14:0] atlas_coord(longint twice_t, longint sz);
    longint d;
    d = (sz == 0) ? 1 : sz;
    return 15'(clip(round_quot(twice_t * 16384, d), 0, 32767));
  endfunction

  function automatic void push_quad(item_t it);
    longint      rx, ry, rw, rh, x0, y0, tx, ty, tw, th, cx, cy, s, c, dx, dy, px, py;
    longint      xs[4], ys[4];
    logic [14:0] us[4], vs[4];
    logic [15:0] ang;
    vertex_t     v;
    rx = longint'(it.rect_x);  ry = longint'(it.rect_y);
    rw = longint'(it.rect_w);  rh = longint'(it.rect_h);
    x0 = rx + longint'(it.shift_x);
    y0 = ry + longint'(it.shift_y);
    tx = longint'(it.tex_x);   ty = longint'(it.tex_y);
    tw = longint'(it.tex_w);   th = longint'(it.tex_h);
    xs = '{x0, x0 + rw, x0 + rw, x0};
    ys = '{y0, y0, y0 + rh, y0 + rh};
    us[0] = atlas_coord(2 * tx + 1, atlas_w);
    us[1] = atlas_coord(2 * (tx + tw) - 1, atlas_w);
    vs[2] = atlas_coord(2 * ty + 1, atlas_h);
    vs[0] = atlas_coord(2 * (ty + th) - 1, atlas_h);
    us[2] = us[1]; us[3] = us[0];
    vs[1] = vs[0]; vs[3] = vs[2];
    cx = rx + rw / 2;
    cy = ry + rh / 2;
    s = 0; c = 16384;
    ang = it.turn_angle & 16'(32'hFFFF << (16 - SINE_TABLE_BITS));
    if (it.turn_angle != 0) sin_cos(ang, s, c);
    for (int k = 0; k < 4; k++) begin
      if (it.turn_angle != 0) begin
        dx = xs[k] - cx;
        dy = ys[k] - cy;
        px = cx * 16384 + dx * c - dy * s;
        py = cy * 16384 + dx * s + dy * c;
      end else begin
        px = xs[k] * 16384;
        py = ys[k] * 16384;
      end
      v.corner = corner_e'(k);
      v.vidx   = 14'((longint'(it.slot) % SLOT_COUNT) * 4 + k);
      v.pos_x  = screen_coord(px, screen_w);
      v.pos_y  = screen_coord(py, screen_h);
      v.tex_u  = us[k];
      v.tex_v  = vs[k];
      v.last   = (k == 3);
      vertex_q.push_back(v);
    end
  endfunction

  task automatic mismatch(string name, longint exp_v, longint act_v);
    $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t e;
    if (!rst_ni) begin
      screen_w = 640; screen_h = 480; atlas_w = 1024; atlas_h = 1024;
      fail_count_o = 0;
      vertex_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCREEN_W: screen_w = cfg_data_i;
          CFG_SCREEN_H: screen_h = cfg_data_i;
          CFG_ATLAS_W:  atlas_w = cfg_data_i & 15'h3FFF;
          CFG_ATLAS_H:  atlas_h = cfg_data_i & 15'h3FFF;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (vertex_q.size() == 0) begin
          $error("vertex transfer with nothing expected");
          fail_count_o++;
        end else begin
          e = vertex_q.pop_front();
          if (corner_i != e.corner) mismatch("corner", e.corner, corner_i);
          if (vertex_index_i != e.vidx) mismatch("vertex_index", e.vidx, vertex_index_i);
          if (pos_x_i != e.pos_x)
            mismatch("pos_x", longint'(signed'(e.pos_x)), longint'(signed'(pos_x_i)));
          if (pos_y_i != e.pos_y)
            mismatch("pos_y", longint'(signed'(e.pos_y)), longint'(signed'(pos_y_i)));
          if (tex_u_i != e.tex_u) mismatch("tex_u", e.tex_u, tex_u_i);
          if (tex_v_i != e.tex_v) mismatch("tex_v", e.tex_v, tex_v_i);
          if (last_i != e.last) mismatch("last", e.last, last_i);
        end
      end
      if (in_valid_i && !in_stall_i) push_quad(sprite_i);
    end
  end

endmodule

// ===== tb/sv/sprite_quad_vertex_setup_top_test.sv =====
`timescale 1ns / 100ps

module sprite_quad_vertex_setup_top_test;
  import sqvs_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_e    cfg_idx = CFG_SCREEN_W;
  logic [14:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  item_t       sprite = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  corner;
  logic [13:0] vertex_index;
  logic [15:0] pos_x, pos_y;
  logic [14:0] tex_u, tex_v;
  logic        last;
  int          fail_count, pending, cycles = 0, hold_left = 0;
  bit          calm = 0, hold_go = 0, held = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sprite_quad_vertex_setup_top u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .rect_x_i(sprite.rect_x), .rect_y_i(sprite.rect_y),
    .rect_w_i(sprite.rect_w), .rect_h_i(sprite.rect_h),
    .shift_x_i(sprite.shift_x), .shift_y_i(sprite.shift_y),
    .tex_x_i(sprite.tex_x), .tex_y_i(sprite.tex_y),
    .tex_w_i(sprite.tex_w), .tex_h_i(sprite.tex_h),
    .turn_angle_i(sprite.turn_angle), .slot_i(sprite.slot),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .corner_o(corner), .vertex_index_o(vertex_index),
    .pos_x_o(pos_x), .pos_y_o(pos_y), .tex_u_o(tex_u), .tex_v_o(tex_v),
    .last_o(last)
  );

  sprite_quad_vertex_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .sprite_i(sprite),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .corner_i(corner), .vertex_index_i(vertex_index),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .tex_u_i(tex_u), .tex_v_i(tex_v),
    .last_i(last),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("sprite_quad_vertex_setup_top_test NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !held) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      held <= 1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 36);
    end
  end

  task automatic send_sprite(item_t it);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sprite <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_sizes(int sw, int sh, int aw, int ah);
    cfg_idx_e idx[4];
    int       val[4];
    idx = '{CFG_SCREEN_W, CFG_SCREEN_H, CFG_ATLAS_W, CFG_ATLAS_H};
    val = '{sw, sh, aw, ah};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_data <= 15'(val[i]);
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic item_t random_sprite();
    item_t it;
    it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(3) != 0) begin
      it.rect_x = 16'($urandom_range(900) - 100);
      it.rect_y = 16'($urandom_range(700) - 100);
      it.rect_w = 15'($urandom_range(256));
      it.rect_h = 15'($urandom_range(256));
      it.shift_x = 16'($urandom_range(64) - 32);
      it.shift_y = 16'($urandom_range(64) - 32);
      it.tex_x = 13'($urandom_range(1023));
      it.tex_y = 13'($urandom_range(1023));
      it.tex_w = 14'($urandom_range(256));
      it.tex_h = 14'($urandom_range(256));
      if ($urandom_range(2) == 0) it.turn_angle = 0;
    end else begin
      it.tex_w = 14'($urandom_range(8192));
      it.tex_h = 14'($urandom_range(8192));
    end
    return it;
  endfunction

  function automatic item_t basic_sprite(logic [15:0] ang);
    item_t it;
    it = '0;
    it.rect_x = 100; it.rect_y = 80; it.rect_w = 64; it.rect_h = 33;
    it.shift_x = -5; it.shift_y = 7;
    it.tex_x = 16; it.tex_y = 32; it.tex_w = 64; it.tex_h = 33;
    it.turn_angle = ang; it.slot = 12'd5;
    return it;
  endfunction

  initial begin
    item_t it;
    logic [15:0] angles[9];
    angles = '{16'h0000, 16'h0001, 16'h003F, 16'h2000, 16'h4000,
               16'h8000, 16'hC000, 16'hFFC0, 16'hFFFF};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (angles[i]) send_sprite(basic_sprite(angles[i]));
    it = '0;
    send_sprite(it);
    it = '1;
    it.rect_w = 15'h7FFF; it.tex_w = 14'd8192; it.tex_h = 14'd8192;
    send_sprite(it);
    it = '0;
    it.rect_x = 16'sh8000; it.rect_y = 16'sh8000;
    it.shift_x = 16'sh8000; it.shift_y = 16'sh8000;
    it.rect_w = 15'h7FFF; it.rect_h = 15'h7FFF;
    it.tex_x = 13'h1FFF; it.tex_y = 13'h1FFF; it.tex_w = 14'd8192; it.tex_h = 14'd8192;
    it.turn_angle = 16'h6000; it.slot = 12'hFFF;
    send_sprite(it);
    it.rect_x = 16'sh7FFF; it.rect_y = 16'sh7FFF;
    it.shift_x = 16'sh7FFF; it.shift_y = 16'sh7FFF;
    it.turn_angle = 16'hA000;
    send_sprite(it);
    settle();

    set_sizes(1, 1, 1, 1);
    for (int i = 0; i < 8; i++) send_sprite(basic_sprite(angles[i]));
    for (int i = 0; i < 12; i++) send_sprite(random_sprite());
    settle();

    set_sizes(16384, 16384, 8192, 8192);
    calm = 1;
    for (int i = 0; i < 30; i++) send_sprite(random_sprite());
    calm = 0;
    settle();

    set_sizes($urandom_range(1, 16384), $urandom_range(1, 16384),
              $urandom_range(1, 8192), $urandom_range(1, 8192));
    hold_go = 1;
    for (int i = 0; i < 30; i++) send_sprite(random_sprite());
    hold_go = 0;
    settle();

    set_sizes(640, 480, 1024, 1024);
    for (int i = 0; i < 45; i++) send_sprite(random_sprite());
    settle();

    if (fail_count == 0) begin
      $display("sprite_quad_vertex_setup_top_test OK");
    end else begin
      $display("sprite_quad_vertex_setup_top_test NOT OK");
    end
    $finish;
  end

endmodule
